>>> src/rti_pkg.sv
// ----------------------------------------------------------------------------
// Ray / triangle intersection package
// Payload types, register indexes and fixed widths shared by the block.
// ----------------------------------------------------------------------------
package rti_pkg;

	// Width of every exact dot product (magnitudes stay below 2^99).
	localparam int DW = 100;
	// Quotient bits produced by each divider.
	localparam int QB = 33;
	// Remainder width inside the dividers.
	localparam int RW = DW + QB;
	// Fraction bits of the barycentric weights.
	localparam int BARY_FRAC_BITS = 16;
	// Width of a coordinate difference.
	localparam int CW = 33;

	localparam logic signed [31:0] DIR_Z_RESET = 32'sd65536;
	localparam logic [31:0] DET_THR_RESET = 32'd1;

	typedef enum logic [2:0] {
		REG_ORG_X,
		REG_ORG_Y,
		REG_ORG_Z,
		REG_DIR_X,
		REG_DIR_Y,
		REG_DIR_Z,
		REG_DET_THR
	} reg_idx_t;

	typedef struct packed {
		logic signed [31:0] vert_a_x;
		logic signed [31:0] vert_a_y;
		logic signed [31:0] vert_a_z;
		logic signed [31:0] vert_b_x;
		logic signed [31:0] vert_b_y;
		logic signed [31:0] vert_b_z;
		logic signed [31:0] vert_c_x;
		logic signed [31:0] vert_c_y;
		logic signed [31:0] vert_c_z;
	} tri_item_t;

	typedef struct packed {
		logic               hit;
		logic signed [31:0] ray_param;
		logic [16:0]        bary_u;
		logic [16:0]        bary_v;
	} res_item_t;

	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
	} vec32_t;

	// Edges and origin offset of one triangle.
	typedef struct packed {
		logic signed [CW-1:0] e1_x;
		logic signed [CW-1:0] e1_y;
		logic signed [CW-1:0] e1_z;
		logic signed [CW-1:0] e2_x;
		logic signed [CW-1:0] e2_y;
		logic signed [CW-1:0] e2_z;
		logic signed [CW-1:0] tv_x;
		logic signed [CW-1:0] tv_y;
		logic signed [CW-1:0] tv_z;
	} geom_t;

	// Status that travels beside the dividers.
	typedef struct packed {
		logic vld;
		logic hit;
		logic tneg;
	} side_t;

	function automatic logic signed [CW-1:0] sub33(input logic signed [31:0] a,
			input logic signed [31:0] b);
		sub33 = CW'(a) - CW'(b);
	endfunction

endpackage

>>> src/ray_triangle_intersect.sv
// ----------------------------------------------------------------------------
// Ray / triangle intersection
// Tests a stream of triangles against one ray with the Moller-Trumbore method.
// ----------------------------------------------------------------------------
// Usage: write the ray origin, direction and determinant threshold through the
// configuration channel (cfg_valid / cfg_ready, always ready) while the block
// is idle. Triangles enter as a queue: a transfer happens when push is high
// and full is low. Results leave as a queue: while empty is low the oldest
// result sits on the result port, and it is transferred when pop is high.
// Every triangle gives exactly one result, in order.
// Throughput is one triangle per cycle while full stays low. A triangle passes
// from the push transfer to the result port through one front stage, the queue
// between front and back, six product and test stages and the 35-stage divider
// pipelines (an input register, one overflow step and 33 quotient bits).
// When the receiver stalls, a two-entry result queue fills, the whole back
// pipeline freezes, the middle queue fills and then full rises; nothing is
// lost. Reset clears all queues and pipeline valids and loads the register
// defaults (direction along +z, threshold 1).
// ----------------------------------------------------------------------------
module ray_triangle_intersect #(
	parameter int COORD_FRAC_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  rti_pkg::tri_item_t triangle,
	output logic               full,
	input  logic               pop,
	output rti_pkg::res_item_t result,
	output logic               empty,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data
);
	import rti_pkg::*;

	vec32_t      org_q;
	vec32_t      dir_q;
	logic [31:0] thr_q;

	logic        q_push, q_full, q_pop, q_empty;
	geom_t       q_wdata, q_rdata;
	logic        out_push, out_full;
	res_item_t   out_data;

	// The register file never stalls a write.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			org_q   <= '0;
			dir_q.x <= '0;
			dir_q.y <= '0;
			dir_q.z <= DIR_Z_RESET;
			thr_q   <= DET_THR_RESET;
		end else if (cfg_valid) begin
			unique case (reg_idx_t'(cfg_index))
				REG_ORG_X:   org_q.x <= cfg_data;
				REG_ORG_Y:   org_q.y <= cfg_data;
				REG_ORG_Z:   org_q.z <= cfg_data;
				REG_DIR_X:   dir_q.x <= cfg_data;
				REG_DIR_Y:   dir_q.y <= cfg_data;
				REG_DIR_Z:   dir_q.z <= cfg_data;
				REG_DET_THR: thr_q   <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Front end: edges and origin offset.
	rti_front u_front (
		.clk(clk), .arst_n(arst_n), .push(push), .triangle(triangle), .full(full),
		.org(org_q), .q_push(q_push), .q_data(q_wdata), .q_full(q_full)
	);

	// Decoupling queue between front and back.
	rti_fifo #(.T(geom_t), .DEPTH(4)) u_mid_q (
		.clk(clk), .arst_n(arst_n), .push(q_push), .wdata(q_wdata), .full(q_full),
		.pop(q_pop), .rdata(q_rdata), .empty(q_empty)
	);

	// Back end: products, tests and divisions.
	rti_back #(.COORD_FRAC_BITS(COORD_FRAC_BITS)) u_back (
		.clk(clk), .arst_n(arst_n), .q_empty(q_empty), .q_data(q_rdata),
		.q_pop(q_pop), .dir(dir_q), .det_thr(thr_q), .out_full(out_full),
		.out_push(out_push), .out_data(out_data)
	);

	// Result queue; it keeps the back pipeline apart from the receiver.
	rti_fifo #(.T(res_item_t), .DEPTH(2)) u_out_q (
		.clk(clk), .arst_n(arst_n), .push(out_push), .wdata(out_data),
		.full(out_full), .pop(pop), .rdata(result), .empty(empty)
	);

`ifndef ASSERT_OFF
	a_out_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		out_push |-> !out_full)
		else $error("result pushed into a full queue");

	a_mid_no_underrun: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_empty)
		else $error("back end popped an empty queue");

	a_miss_is_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !result.hit) |->
		(result.ray_param == '0 && result.bary_u == '0 && result.bary_v == '0))
		else $error("miss carries nonzero numbers");

	a_bary_sum: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result.hit) |->
		((18'(result.bary_u) + 18'(result.bary_v)) <= 18'd65536))
		else $error("barycentric weights sum above one");
`endif
endmodule

>>> src/rti_fifo.sv
// ----------------------------------------------------------------------------
// Small queue
// Register based first-in first-out buffer; DEPTH must be a power of two.
// ----------------------------------------------------------------------------
module rti_fifo #(
	parameter type T = logic,
	parameter int DEPTH = 4
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  T     wdata,
	output logic full,
	input  logic pop,
	output T     rdata,
	output logic empty
);
	localparam int AW = $clog2(DEPTH);

	T                mem_q [DEPTH];
	logic [AW-1:0]   wr_ptr_q;
	logic [AW-1:0]   rd_ptr_q;
	logic [AW:0]     cnt_q;
	logic            do_push;
	logic            do_pop;

	assign full    = (cnt_q == (AW+1)'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end
endmodule

>>> src/rti_front.sv
// ----------------------------------------------------------------------------
// Ray / triangle front end
// Takes triangles and forms the edges e1 and e2 and the origin offset.
// ----------------------------------------------------------------------------
module rti_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  rti_pkg::tri_item_t triangle,
	output logic              full,
	input  rti_pkg::vec32_t   org,
	output logic              q_push,
	output rti_pkg::geom_t    q_data,
	input  logic              q_full
);
	import rti_pkg::*;

	logic  vld_s1;
	geom_t geo_s1;
	logic  take;

	assign full   = vld_s1 && q_full;
	assign take   = push && !full;
	assign q_push = vld_s1 && !q_full;
	assign q_data = geo_s1;

	always_ff @(posedge clk) begin
		if (take) begin
			geo_s1.e1_x <= sub33(triangle.vert_b_x, triangle.vert_a_x);
			geo_s1.e1_y <= sub33(triangle.vert_b_y, triangle.vert_a_y);
			geo_s1.e1_z <= sub33(triangle.vert_b_z, triangle.vert_a_z);
			geo_s1.e2_x <= sub33(triangle.vert_c_x, triangle.vert_a_x);
			geo_s1.e2_y <= sub33(triangle.vert_c_y, triangle.vert_a_y);
			geo_s1.e2_z <= sub33(triangle.vert_c_z, triangle.vert_a_z);
			geo_s1.tv_x <= sub33(org.x, triangle.vert_a_x);
			geo_s1.tv_y <= sub33(org.y, triangle.vert_a_y);
			geo_s1.tv_z <= sub33(org.z, triangle.vert_a_z);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (take) begin
			vld_s1 <= 1'b1;
		end else if (q_push) begin
			vld_s1 <= 1'b0;
		end
	end
endmodule

>>> src/rti_div.sv
// ----------------------------------------------------------------------------
// Pipelined restoring divider
// One quotient bit per stage, with an overflow stage in front.
// ----------------------------------------------------------------------------
module rti_div #(
	parameter int DWID = 100,
	parameter int QBITS = 33
) (
	input  logic                   clk,
	input  logic                   en,
	input  logic [DWID+QBITS-1:0]  num,
	input  logic [DWID-1:0]        den,
	output logic [QBITS-1:0]       quo,
	output logic                   ovf
);
	localparam int RWID = DWID + QBITS;
	localparam int NST  = QBITS + 2;

	logic [RWID-1:0]  rem_q [NST];
	logic [DWID-1:0]  den_q [NST];
	logic [QBITS-1:0] quo_q [NST];
	logic             ovf_q [NST];

	logic [RWID-1:0]  rem_n [NST];
	logic [QBITS-1:0] quo_n [NST];
	logic             ovf_n [NST];
	logic [RWID-1:0]  dsh;

	always_comb begin
		dsh      = '0;
		rem_n[0] = num;
		quo_n[0] = '0;
		ovf_n[0] = 1'b0;
		rem_n[1] = rem_q[0];
		quo_n[1] = '0;
		ovf_n[1] = rem_q[0] >= (RWID'(den_q[0]) << QBITS);
		for (int k = 2; k < NST; k++) begin
			dsh      = RWID'(den_q[k-1]) << (NST - 1 - k);
			rem_n[k] = rem_q[k-1];
			quo_n[k] = quo_q[k-1];
			ovf_n[k] = ovf_q[k-1];
			if (rem_q[k-1] >= dsh) begin
				rem_n[k] = rem_q[k-1] - dsh;
				quo_n[k][NST-1-k] = 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			den_q[0] <= den;
			for (int k = 0; k < NST; k++) begin
				rem_q[k] <= rem_n[k];
				quo_q[k] <= quo_n[k];
				ovf_q[k] <= ovf_n[k];
			end
			for (int k = 1; k < NST; k++) begin
				den_q[k] <= den_q[k-1];
			end
		end
	end

	assign quo = quo_q[NST-1];
	assign ovf = ovf_q[NST-1];
endmodule

>>> src/rti_back.sv
// ----------------------------------------------------------------------------
// Ray / triangle back end
// Exact cross and dot products, hit tests and the three divisions.
// ----------------------------------------------------------------------------
module rti_back #(
	parameter int COORD_FRAC_BITS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_empty,
	input  rti_pkg::geom_t      q_data,
	output logic                q_pop,
	input  rti_pkg::vec32_t     dir,
	input  logic [31:0]         det_thr,
	input  logic                out_full,
	output logic                out_push,
	output rti_pkg::res_item_t  out_data
);
	import rti_pkg::*;

	localparam int L      = QB + 2;
	localparam int LOBITS = 34;

	logic adv;

	logic signed [CW-1:0] ma [12];
	logic signed [CW-1:0] mb [12];
	logic signed [65:0]   prod_s1 [12];
	geom_t                geo_s1;
	logic                 vld_s1;

	logic signed [66:0]   pv_s2 [3];
	logic signed [66:0]   qv_s2 [3];
	geom_t                geo_s2;
	logic                 vld_s2;

	logic signed [CW-1:0] da [12];
	logic signed [66:0]   db [12];
	logic signed [67:0]   plo_s3 [12];
	logic signed [65:0]   phi_s3 [12];
	logic                 vld_s3;

	logic signed [DW-1:0] pf_s4 [12];
	logic                 vld_s4;

	logic signed [DW-1:0] det_s5, un_s5, vn_s5, tn_s5;
	logic                 vld_s5;

	logic [DW-1:0]        det_s6, tn_s6;
	logic signed [DW-1:0] un_s6, vn_s6;
	logic                 tneg_s6, dzero_s6, vld_s6;

	logic                 detneg;
	logic                 miss;
	logic [DW:0]          uv_sum;
	logic [RW-1:0]        num_t, num_u, num_v;
	side_t                side_q [L];
	side_t                side_n;

	logic [QB-1:0]        qt, qu, qv;
	logic                 ovt, ovu, ovv;
	logic [QB-1:0]        lim, qsat;
	logic signed [31:0]   rp;

	assign adv   = !side_q[L-1].vld || !out_full;
	assign q_pop = adv && !q_empty;

	// First products: pv = dir x e2, qv = tv x e1.
	always_comb begin
		ma[0]  = CW'(dir.y);   mb[0]  = q_data.e2_z;
		ma[1]  = CW'(dir.z);   mb[1]  = q_data.e2_y;
		ma[2]  = CW'(dir.z);   mb[2]  = q_data.e2_x;
		ma[3]  = CW'(dir.x);   mb[3]  = q_data.e2_z;
		ma[4]  = CW'(dir.x);   mb[4]  = q_data.e2_y;
		ma[5]  = CW'(dir.y);   mb[5]  = q_data.e2_x;
		ma[6]  = q_data.tv_y;  mb[6]  = q_data.e1_z;
		ma[7]  = q_data.tv_z;  mb[7]  = q_data.e1_y;
		ma[8]  = q_data.tv_z;  mb[8]  = q_data.e1_x;
		ma[9]  = q_data.tv_x;  mb[9]  = q_data.e1_z;
		ma[10] = q_data.tv_x;  mb[10] = q_data.e1_y;
		ma[11] = q_data.tv_y;  mb[11] = q_data.e1_x;
	end

	// Dot products: det = e1.pv, un = tv.pv, vn = dir.qv, tn = e2.qv.
	always_comb begin
		da[0]  = geo_s2.e1_x;  db[0]  = pv_s2[0];
		da[1]  = geo_s2.e1_y;  db[1]  = pv_s2[1];
		da[2]  = geo_s2.e1_z;  db[2]  = pv_s2[2];
		da[3]  = geo_s2.tv_x;  db[3]  = pv_s2[0];
		da[4]  = geo_s2.tv_y;  db[4]  = pv_s2[1];
		da[5]  = geo_s2.tv_z;  db[5]  = pv_s2[2];
		da[6]  = CW'(dir.x);   db[6]  = qv_s2[0];
		da[7]  = CW'(dir.y);   db[7]  = qv_s2[1];
		da[8]  = CW'(dir.z);   db[8]  = qv_s2[2];
		da[9]  = geo_s2.e2_x;  db[9]  = qv_s2[0];
		da[10] = geo_s2.e2_y;  db[10] = qv_s2[1];
		da[11] = geo_s2.e2_z;  db[11] = qv_s2[2];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			geo_s1 <= q_data;
			for (int k = 0; k < 12; k++) begin
				prod_s1[k] <= 66'(ma[k]) * 66'(mb[k]);
			end

			geo_s2 <= geo_s1;
			for (int j = 0; j < 3; j++) begin
				pv_s2[j] <= 67'(prod_s1[2*j]) - 67'(prod_s1[2*j+1]);
				qv_s2[j] <= 67'(prod_s1[2*j+6]) - 67'(prod_s1[2*j+7]);
			end

			// Each wide product is split into a low unsigned and a high signed half.
			for (int k = 0; k < 12; k++) begin
				plo_s3[k] <= 68'(da[k]) * 68'($signed({1'b0, db[k][LOBITS-1:0]}));
				phi_s3[k] <= 66'(da[k]) * 66'($signed(db[k][66:LOBITS]));
			end

			for (int k = 0; k < 12; k++) begin
				pf_s4[k] <= (DW'(phi_s3[k]) <<< LOBITS) + DW'(plo_s3[k]);
			end

			det_s5 <= pf_s4[0] + pf_s4[1] + pf_s4[2];
			un_s5  <= pf_s4[3] + pf_s4[4] + pf_s4[5];
			vn_s5  <= pf_s4[6] + pf_s4[7] + pf_s4[8];
			tn_s5  <= pf_s4[9] + pf_s4[10] + pf_s4[11];

			// Fold the determinant sign into the numerators.
			det_s6   <= detneg ? $unsigned(-det_s5) : $unsigned(det_s5);
			un_s6    <= detneg ? -un_s5 : un_s5;
			vn_s6    <= detneg ? -vn_s5 : vn_s5;
			tn_s6    <= tn_s5[DW-1] ? $unsigned(-tn_s5) : $unsigned(tn_s5);
			tneg_s6  <= (tn_s5 != '0) && (tn_s5[DW-1] ^ detneg);
			dzero_s6 <= (det_s5 == '0);
		end
	end

	assign detneg = det_s5[DW-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			for (int k = 0; k < L; k++) begin
				side_q[k] <= '0;
			end
		end else if (adv) begin
			vld_s1    <= !q_empty;
			vld_s2    <= vld_s1;
			vld_s3    <= vld_s2;
			vld_s4    <= vld_s3;
			vld_s5    <= vld_s4;
			vld_s6    <= vld_s5;
			side_q[0] <= side_n;
			for (int k = 1; k < L; k++) begin
				side_q[k] <= side_q[k-1];
			end
		end
	end

	// Rejection tests, all exact.
	always_comb begin
		uv_sum = (DW+1)'($unsigned(un_s6)) + (DW+1)'($unsigned(vn_s6));
		miss   = dzero_s6
			|| (det_s6 < DW'(det_thr))
			|| un_s6[DW-1]
			|| ($unsigned(un_s6) > det_s6)
			|| vn_s6[DW-1]
			|| (uv_sum > (DW+1)'(det_s6));
		side_n.vld  = vld_s6;
		side_n.hit  = !miss;
		side_n.tneg = tneg_s6;
		num_t = RW'(tn_s6) << COORD_FRAC_BITS;
		num_u = RW'($unsigned(un_s6)) << BARY_FRAC_BITS;
		num_v = RW'($unsigned(vn_s6)) << BARY_FRAC_BITS;
	end

	rti_div #(.DWID(DW), .QBITS(QB)) u_div_t (
		.clk(clk), .en(adv), .num(num_t), .den(det_s6), .quo(qt), .ovf(ovt)
	);
	rti_div #(.DWID(DW), .QBITS(QB)) u_div_u (
		.clk(clk), .en(adv), .num(num_u), .den(det_s6), .quo(qu), .ovf(ovu)
	);
	rti_div #(.DWID(DW), .QBITS(QB)) u_div_v (
		.clk(clk), .en(adv), .num(num_v), .den(det_s6), .quo(qv), .ovf(ovv)
	);

	// Saturate t and clear everything on a miss.
	always_comb begin
		lim  = side_q[L-1].tneg ? QB'(33'h0_8000_0000) : QB'(33'h0_7FFF_FFFF);
		qsat = (ovt || (qt > lim)) ? lim : qt;
		rp   = side_q[L-1].tneg ? -$signed(qsat[31:0]) : $signed(qsat[31:0]);
		out_data.hit       = side_q[L-1].hit;
		out_data.ray_param = side_q[L-1].hit ? rp : '0;
		out_data.bary_u    = (side_q[L-1].hit && !ovu) ? qu[16:0] : '0;
		out_data.bary_v    = (side_q[L-1].hit && !ovv) ? qv[16:0] : '0;
	end

	assign out_push = side_q[L-1].vld && !out_full;
endmodule

>>> tb/tb_ray_triangle_intersect.sv
// ----------------------------------------------------------------------------
// Ray / triangle intersection testbench
// Streams triangles against several ray settings and checks every result
// against an exact wide-integer intersection predictor kept in the bench.
// ----------------------------------------------------------------------------
module tb_ray_triangle_intersect;

	import rti_pkg::*;

	localparam int FRAC = 16;
	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 60;
	// Index 7 is not a register; writes there must change nothing.
	localparam logic [2:0] REG_NONE = 3'd7;

	// Wide enough for every exact product and dot product of the test.
	typedef logic signed [159:0] wide_t;

	typedef enum logic [1:0] {
		OP_TRI,
		OP_CFG,
		OP_DRAIN,
		OP_MODE
	} op_kind_t;

	typedef struct {
		op_kind_t   kind;
		tri_item_t  tri_data;
		logic [2:0] idx;
		logic [31:0] data;
	} op_t;

	logic clk;
	logic arst_n;
	logic push;
	tri_item_t triangle;
	logic full;
	logic pop;
	res_item_t result;
	logic empty;
	logic cfg_valid;
	logic cfg_ready;
	logic [2:0] cfg_index;
	logic [31:0] cfg_data;

	op_t pending_ops[$];
	res_item_t awaited_results[$];
	logic [31:0] shadow_regs[7];
	int send_idle_pct;
	int recv_idle_pct;
	int error_count;
	int cycle_count;

	ray_triangle_intersect #(
		.COORD_FRAC_BITS(FRAC)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.triangle(triangle),
		.full(full),
		.pop(pop),
		.result(result),
		.empty(empty),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic wide_t widen(input logic signed [31:0] v);
		wide_t w;
		w = v;
		return w;
	endfunction

	// Exact Moller-Trumbore test against the ray held in shadow_regs. All
	// sums and products are exact; only the three quotients truncate.
	function automatic res_item_t intersect_ray(input tri_item_t t);
		wide_t ox, oy, oz, dx, dy, dz, thr;
		wide_t e1x, e1y, e1z, e2x, e2y, e2z, tvx, tvy, tvz;
		wide_t px, py, pz, qx, qy, qz;
		wide_t det, un, vn, tn, quo, lim;
		logic tneg;
		res_item_t r;
		r = '0;
		ox = widen(shadow_regs[REG_ORG_X]);
		oy = widen(shadow_regs[REG_ORG_Y]);
		oz = widen(shadow_regs[REG_ORG_Z]);
		dx = widen(shadow_regs[REG_DIR_X]);
		dy = widen(shadow_regs[REG_DIR_Y]);
		dz = widen(shadow_regs[REG_DIR_Z]);
		thr = {128'd0, shadow_regs[REG_DET_THR]};
		e1x = widen(t.vert_b_x) - widen(t.vert_a_x);
		e1y = widen(t.vert_b_y) - widen(t.vert_a_y);
		e1z = widen(t.vert_b_z) - widen(t.vert_a_z);
		e2x = widen(t.vert_c_x) - widen(t.vert_a_x);
		e2y = widen(t.vert_c_y) - widen(t.vert_a_y);
		e2z = widen(t.vert_c_z) - widen(t.vert_a_z);
		px = dy * e2z - dz * e2y;
		py = dz * e2x - dx * e2z;
		pz = dx * e2y - dy * e2x;
		det = e1x * px + e1y * py + e1z * pz;
		if (det == 0)
			return r;
		tvx = ox - widen(t.vert_a_x);
		tvy = oy - widen(t.vert_a_y);
		tvz = oz - widen(t.vert_a_z);
		qx = tvy * e1z - tvz * e1y;
		qy = tvz * e1x - tvx * e1z;
		qz = tvx * e1y - tvy * e1x;
		un = tvx * px + tvy * py + tvz * pz;
		vn = dx * qx + dy * qy + dz * qz;
		tn = e2x * qx + e2y * qy + e2z * qz;
		if (det < 0) begin
			det = -det;
			un = -un;
			vn = -vn;
			tn = -tn;
		end
		if (det < thr)
			return r;
		if (un < 0 || un > det)
			return r;
		if (vn < 0 || un + vn > det)
			return r;
		tneg = tn < 0;
		if (tneg)
			tn = -tn;
		quo = (tn <<< FRAC) / det;
		lim = tneg ? wide_t'(64'h8000_0000) : wide_t'(64'h7FFF_FFFF);
		if (quo > lim)
			quo = lim;
		r.hit = 1'b1;
		r.ray_param = tneg ? -quo[31:0] : quo[31:0];
		r.bary_u = 17'((un <<< BARY_FRAC_BITS) / det);
		r.bary_v = 17'((vn <<< BARY_FRAC_BITS) / det);
		return r;
	endfunction

	task automatic report_mismatch(input string field, input logic [31:0] got,
			input logic [31:0] want);
		$display("[%0d] mismatch on %s: got %h, expected %h", cycle_count, field,
			got, want);
		error_count++;
	endtask

	function automatic int q16(input int whole);
		return whole <<< FRAC;
	endfunction

	function automatic tri_item_t mk_tri(input int ax, ay, az, bx, by, bz,
			input int cx, cy, cz);
		tri_item_t t;
		t = {ax, ay, az, bx, by, bz, cx, cy, cz};
		return t;
	endfunction

	function automatic int spread(input int s);
		return int'($urandom_range(2 * s)) - s;
	endfunction

	// Most triangles are placed around the point (cx, cy, cz) so that rays
	// near it hit often; the rest are raw bit patterns or degenerate ones.
	function automatic tri_item_t rand_tri(input int cx, cy, cz);
		tri_item_t t;
		int s, pick;
		pick = $urandom_range(99);
		s = $urandom_range(1, 6) <<< FRAC;
		if (pick < 70) begin
			t = mk_tri(cx + spread(s), cy + spread(s), cz + spread(s),
				cx + spread(s), cy + spread(s), cz + spread(s),
				cx + spread(s), cy + spread(s), cz + spread(s));
		end else if (pick < 85) begin
			t = mk_tri($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
				$urandom, $urandom, $urandom);
		end else begin
			// Degenerate: the third vertex repeats the first or second one.
			t = mk_tri(cx + spread(s), cy + spread(s), cz + spread(s),
				cx + spread(s), cy + spread(s), cz + spread(s), 0, 0, 0);
			if (pick[0]) begin
				t.vert_c_x = t.vert_a_x;
				t.vert_c_y = t.vert_a_y;
				t.vert_c_z = t.vert_a_z;
			end else begin
				t.vert_c_x = t.vert_b_x;
				t.vert_c_y = t.vert_b_y;
				t.vert_c_z = t.vert_b_z;
			end
		end
		return t;
	endfunction

	task automatic add_tri(input tri_item_t t);
		op_t op;
		op.kind = OP_TRI;
		op.tri_data = t;
		op.idx = '0;
		op.data = '0;
		pending_ops.insert(pending_ops.size(), op);
	endtask

	task automatic add_rand(input int n, input int cx, cy, cz);
		for (int i = 0; i < n; i++)
			add_tri(rand_tri(cx, cy, cz));
	endtask

	task automatic add_ctl(input op_kind_t kind, input logic [2:0] idx,
			input logic [31:0] data);
		op_t op;
		op.kind = kind;
		op.tri_data = '0;
		op.idx = idx;
		op.data = data;
		pending_ops.insert(pending_ops.size(), op);
	endtask

	// Writes all seven registers as one ray setting.
	task automatic add_ray(input int ox, oy, oz, dx, dy, dz, input logic [31:0] thr);
		add_ctl(OP_CFG, REG_ORG_X, ox);
		add_ctl(OP_CFG, REG_ORG_Y, oy);
		add_ctl(OP_CFG, REG_ORG_Z, oz);
		add_ctl(OP_CFG, REG_DIR_X, dx);
		add_ctl(OP_CFG, REG_DIR_Y, dy);
		add_ctl(OP_CFG, REG_DIR_Z, dz);
		add_ctl(OP_CFG, REG_DET_THR, thr);
	endtask

	task automatic fill_stimulus();
		add_ctl(OP_MODE, '0, {16'd82, 16'd37});
		// Directed triangles against the reset ray (origin 0, along +z).
		add_tri(mk_tri(q16(-1), q16(-1), q16(5), q16(2), q16(-1), q16(5),
			q16(-1), q16(2), q16(5)));
		// Same triangle wound the other way: positive determinant.
		add_tri(mk_tri(q16(-1), q16(-1), q16(5), q16(-1), q16(2), q16(5),
			q16(2), q16(-1), q16(5)));
		// Triangle behind the origin gives a negative ray parameter.
		add_tri(mk_tri(q16(-1), q16(-1), q16(-5), q16(2), q16(-1), q16(-5),
			q16(-1), q16(2), q16(-5)));
		// The ray passes through a vertex: u = 0 and v = 0.
		add_tri(mk_tri(0, 0, q16(3), q16(1), 0, q16(3), 0, q16(1), q16(3)));
		// Through the second vertex: u = 1 exactly.
		add_tri(mk_tri(q16(-1), 0, q16(3), 0, 0, q16(3), q16(-1), q16(1), q16(3)));
		// Through the third vertex: v = 1 exactly.
		add_tri(mk_tri(q16(-1), 0, q16(3), q16(-1), q16(1), q16(3), 0, 0, q16(3)));
		// On the edge between second and third vertex: u + v = 1.
		add_tri(mk_tri(q16(-1), q16(-1), q16(2), q16(1), q16(-1), q16(2),
			q16(-1), q16(1), q16(2)));
		// Just outside on each side, then one well clear of the ray.
		add_tri(mk_tri(1, 0, q16(3), q16(1), 0, q16(3), 1, q16(1), q16(3)));
		add_tri(mk_tri(0, 1, q16(3), q16(1), 1, q16(3), 0, q16(1), q16(3)));
		add_tri(mk_tri(q16(-1), q16(-1), q16(2), q16(1), q16(-1), q16(2),
			q16(-1), q16(1) - 1, q16(2)) );
		add_tri(mk_tri(q16(1), q16(1), q16(4), q16(2), q16(1), q16(4),
			q16(1), q16(2), q16(4)));
		// Plane containing the ray direction: zero determinant.
		add_tri(mk_tri(q16(-1), 0, q16(1), q16(1), 0, q16(1), 0, 0, q16(4)));
		// All three vertices equal.
		add_tri(mk_tri(q16(1), q16(1), q16(1), q16(1), q16(1), q16(1),
			q16(1), q16(1), q16(1)));
		// Field extremes.
		add_tri(mk_tri(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000,
			32'h80000000, 32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF));
		add_tri(mk_tri(32'h80000000, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF,
			32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF));
		add_tri(mk_tri(32'h80000000, 32'h80000000, 32'h80000000, 32'h7FFFFFFF,
			32'h80000000, 32'h80000000, 32'h80000000, 32'h7FFFFFFF, 32'h80000000));
		add_tri('1);
		add_tri('0);
		// Huge flat triangle far along the ray; the ray passes just outside its long edge.
		add_tri(mk_tri(32'h80000000, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF,
			32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF));

		// Mild ray slightly off axis; a write to the unused index follows.
		add_ray(q16(1) / 4, q16(1) / 10, q16(-3), 655, -1311, q16(1), 32'd1);
		add_ctl(OP_CFG, REG_NONE, 32'hDEAD_BEEF);
		add_rand(360, 0, 0, q16(4));
		// The sender holds off until the block is completely drained.
		add_ctl(OP_DRAIN, '0, '0);
		add_rand(20, 0, 0, q16(4));

		add_ctl(OP_MODE, '0, {16'd37, 16'd82});
		// Extreme registers, threshold zero.
		add_ray(32'h80000000, 32'h80000000, 32'h80000000, 32'h7FFFFFFF,
			32'h7FFFFFFF, 32'h7FFFFFFF, 32'd0);
		add_rand(100, 0, 0, 0);
		add_ray(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000,
			32'h80000000, 32'h80000000, 32'd0);
		add_rand(60, 32'h7FF00000, 32'h7FF00000, 32'h7FF00000);
		// Very short direction vector: t saturates often.
		add_ray(0, 0, 0, 1, 0, 1, 32'd0);
		add_rand(100, 0, 0, q16(1000));
		// Largest threshold: every determinant below it is rejected.
		add_ray(q16(-2), q16(1), q16(-8), 0, 0, q16(2), 32'hFFFFFFFF);
		add_rand(50, q16(-2), q16(1), 0);
		// Random ray near the axis, random threshold.
		add_ray(spread(q16(2)), spread(q16(2)), q16(-6), spread(q16(1) / 8),
			spread(q16(1) / 8), q16(1) + spread(q16(1) / 2), $urandom_range(1 << 20));
		add_rand(230, 0, 0, 0);

		add_ctl(OP_MODE, '0, '0);
		add_ray(q16(1), q16(-1), q16(10), -1000, 700, q16(-1), 32'd1);
		add_rand(230, q16(1), q16(-1), 0);
	endtask

	// Driver: issues triangles and register writes from pending_ops. A write
	// is only issued once every result already predicted has arrived.
	always @(posedge clk) begin : drive_inputs
		logic nxt_push;
		logic nxt_cfg;
		op_t op;
		if (arst_n) begin
			nxt_push = push && full;
			nxt_cfg = cfg_valid && !cfg_ready;
			if (push && !full)
				awaited_results.insert(awaited_results.size(), intersect_ray(triangle));
			if (cfg_valid && cfg_ready && cfg_index <= REG_DET_THR)
				shadow_regs[cfg_index] = cfg_data;
			if (!nxt_push && !nxt_cfg && pending_ops.size() > 0) begin
				op = pending_ops[0];
				case (op.kind)
					OP_MODE: begin
						send_idle_pct = int'(op.data[15:0]);
						recv_idle_pct = int'(op.data[31:16]);
						void'(pending_ops.pop_front());
					end
					OP_DRAIN: begin
						if (awaited_results.size() == 0)
							void'(pending_ops.pop_front());
					end
					OP_CFG: begin
						if (awaited_results.size() == 0 && !push) begin
							cfg_index <= op.idx;
							cfg_data <= op.data;
							nxt_cfg = 1'b1;
							void'(pending_ops.pop_front());
						end
					end
					default: begin
						if ($urandom_range(99) >= send_idle_pct) begin
							triangle <= op.tri_data;
							nxt_push = 1'b1;
							void'(pending_ops.pop_front());
						end
					end
				endcase
			end
			push <= nxt_push;
			cfg_valid <= nxt_cfg;
		end
	end

	// Monitor: checks each popped result against the oldest prediction.
	always @(posedge clk) begin : check_results
		res_item_t want;
		if (arst_n) begin
			if (pop && !empty) begin
				if (awaited_results.size() == 0) begin
					$display("[%0d] result transfer with no result pending", cycle_count);
					error_count++;
				end else begin
					want = awaited_results.pop_front();
					if (result.hit !== want.hit)
						report_mismatch("hit", 32'(result.hit), 32'(want.hit));
					if (result.ray_param !== want.ray_param)
						report_mismatch("ray_param", result.ray_param, want.ray_param);
					if (result.bary_u !== want.bary_u)
						report_mismatch("bary_u", 32'(result.bary_u), 32'(want.bary_u));
					if (result.bary_v !== want.bary_v)
						report_mismatch("bary_v", 32'(result.bary_v), 32'(want.bary_v));
				end
			end
			pop <= $urandom_range(99) >= recv_idle_pct;
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		push = 1'b0;
		pop = 1'b0;
		triangle = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		error_count = 0;
		cycle_count = 0;
		foreach (shadow_regs[i])
			shadow_regs[i] = '0;
		shadow_regs[REG_DIR_Z] = DIR_Z_RESET;
		shadow_regs[REG_DET_THR] = DET_THR_RESET;
		fill_stimulus();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		wait (pending_ops.size() == 0 && !push && !cfg_valid
			&& awaited_results.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0 && awaited_results.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
